// ===== hdl/sars_pkg.sv =====
// Shared types and constants for the selective-ack rate sender.
// Used by the front queue, the execution back end and the top level.
package sars_pkg;

  localparam int WINDOW = 32;
  localparam int WIDX_W = $clog2(WINDOW);
  localparam logic [31:0] WMASK = 32'hFFFF_FFFF >> (32 - WINDOW);

  localparam int IN_DATA_W = 176;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ACCEPT = 2'd1,
    OP_REPORT = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_CONSUMED = 3'd1,
    KIND_STARTED  = 3'd2,
    KIND_STATUS   = 3'd3,
    KIND_CHUNK    = 3'd4,
    KIND_IDLE     = 3'd5
  } kind_t;

  localparam logic [1:0] PST_OK = 2'd0;
  localparam logic [1:0] PST_FINISHED = 2'd1;
  localparam logic [1:0] RSTAT_OK = 2'd0;
  localparam logic [1:0] RSTAT_FINISHED = 2'd1;
  localparam logic [1:0] RSTAT_ABORT = 2'd2;
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_FINISHED = 2'd1;
  localparam logic [1:0] EV_ABORTED = 2'd2;

  localparam logic [7:0] CFG_FILE_LENGTH = 8'd0;
  localparam logic [7:0] CFG_DELAY_STEP = 8'd1;

  typedef enum logic {
    PH_PREP = 1'b0,
    PH_EXEC = 1'b1
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  seqno;
    logic        well_formed;
    logic [1:0]  peer_status;
    logic [15:0] mtu;
    logic [31:0] dt_min;
    logic [31:0] dt_max;
    logic [15:0] session;
    logic [31:0] window_offset;
    logic [31:0] window_mask;
    logic        tx_accepted;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  reply_status;
    logic [31:0] delay;
    logic        rearm_timer;
    logic [1:0]  event_res;
    logic [31:0] chunk_index;
    logic [31:0] file_offset;
    logic [15:0] chunk_length;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t head;
  } queue_out_t;

endpackage

// ===== hdl/selective_ack_rate_sender_top.sv =====
// Top level of the selective-ack rate sender: front queue and back end.
// Depends on sars_pkg, sars_front and sars_back.
//
// Usage: items enter on the s_ stream (operation in s_tuser) and each
// produces exactly one result on the m_ stream (result_kind in m_tuser).
// Registers are written on the cfg channel (index 0 file_length, index 1
// delay_step); the user must do so only while the block is idle, as the
// block does not enforce it. cfg_ready is always high. The back end takes
// each item through a prepare phase (count acknowledged chunks, find the
// first unsent chunk, register its offset product) and an execute phase
// (update the state, load the output register), and takes no new item
// until it has committed the last one. A two-entry queue lets the input
// keep accepting while a result waits. When the receiver stalls, the
// result holds, the back end stops in its execute phase, and s_tready
// falls once the queue is full. Synchronous reset empties the queue and
// output and restores the state and the registers to their reset values.
module selective_ack_rate_sender_top import sars_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // seqno, well_formed, peer_status, mtu, dt_min, dt_max, session,
  // window_offset, window_mask, tx_accepted
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // reply_status, delay, rearm_timer, event_res, chunk_index, file_offset,
  // chunk_length
  output logic [OUT_DATA_W-1:0] m_tdata,
  // result_kind
  output logic [2:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  queue_out_t q_out;
  logic       q_pop;
  result_t    result;

  assign cfg_ready = 1'b1;

  sars_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_out    (q_out),
    .q_pop    (q_pop)
  );

  sars_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_in      (q_out),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_result  (result)
  );

  assign m_tuser = result.result_kind;
  assign m_tdata = {3'd0, result.chunk_length, result.file_offset, result.chunk_index,
                    result.event_res, result.rearm_timer, result.delay,
                    result.reply_status};

endmodule

// ===== hdl/sars_front.sv =====
// Front end: accepts input items, unpacks their fields and holds them in
// a two-entry queue for the back end. Depends on sars_pkg.
module sars_front import sars_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  output queue_out_t           q_out,
  input  logic                 q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      incoming;
  logic       push;

  always_comb begin
    incoming.operation     = s_tuser;
    incoming.seqno         = s_tdata[7:0];
    incoming.well_formed   = s_tdata[8];
    incoming.peer_status   = s_tdata[10:9];
    incoming.mtu           = s_tdata[26:11];
    incoming.dt_min        = s_tdata[58:27];
    incoming.dt_max        = s_tdata[90:59];
    incoming.session       = s_tdata[106:91];
    incoming.window_offset = s_tdata[138:107];
    incoming.window_mask   = s_tdata[170:139] & WMASK;
    incoming.tx_accepted   = s_tdata[171];
  end

  assign s_tready = (count != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_out.valid = (count != 2'd0);
  assign q_out.head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/sars_back.sv =====
// Back end: holds the transfer state and the registers, evaluates one item
// in a prepare phase and an execute phase and writes the result into the
// output register. Depends on sars_pkg.
module sars_back import sars_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  queue_out_t q_in,
  output logic       q_pop,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    m_result
);

  logic [31:0] file_length;
  logic [31:0] delay_step;

  logic        running;
  logic [7:0]  request_seqno;
  logic [15:0] link_mtu;
  logic [15:0] session_id;
  logic [31:0] delay_low;
  logic [31:0] delay_high;
  logic [31:0] delay_now;
  logic [31:0] window_base;
  logic [31:0] sent_mask;
  logic [31:0] reported_mask;
  logic [31:0] acked_total;

  phase_t phase;
  phase_t phase_next;
  logic   commit;

  logic [6:0]        acked_r;
  logic              found_r;
  logic [WIDX_W-1:0] fidx_r;
  logic [31:0]       idx_r;
  logic [31:0]       offs_r;

  item_t             it;
  logic              gt;
  logic [31:0]       base_delta;
  logic [31:0]       adj;
  logic [31:0]       prev_sh;
  logic [6:0]        cnt_old;
  logic [6:0]        cnt_new;
  logic              found;
  logic [WIDX_W-1:0] fidx;
  logic [31:0]       idx_c;

  assign it = q_in.head;

  always_comb begin
    gt = it.window_offset > window_base;
    base_delta = it.window_offset - window_base;
    adj = 32'd0;
    prev_sh = reported_mask;
    cnt_old = 7'd0;
    if (gt) begin
      if (base_delta >= 32'(WINDOW)) begin
        adj = WMASK;
        prev_sh = 32'd0;
      end else begin
        adj = ((it.window_mask << base_delta[4:0]) |
               ~(32'hFFFF_FFFF << base_delta[4:0])) & WMASK;
        prev_sh = reported_mask >> base_delta[4:0];
      end
      cnt_old = 7'($countones(adj & ~reported_mask & WMASK));
    end
    cnt_new = 7'($countones(it.window_mask & ~prev_sh & WMASK));
  end

  always_comb begin
    found = 1'b0;
    fidx = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!sent_mask[i]) begin
        found = 1'b1;
        fidx = WIDX_W'(i);
      end
    end
    idx_c = window_base + 32'(fidx);
  end

  always_ff @(posedge clk) begin
    if (phase == PH_PREP && q_in.valid) begin
      acked_r <= cnt_old + cnt_new;
      found_r <= found;
      fidx_r <= fidx;
      idx_r <= idx_c;
      offs_r <= 32'(idx_c * {16'd0, link_mtu});
    end
  end

  always_comb begin
    phase_next = phase;
    commit = 1'b0;
    unique case (phase)
      PH_PREP: begin
        if (q_in.valid) begin
          phase_next = PH_EXEC;
        end
      end
      PH_EXEC: begin
        if (!m_tvalid || m_tready) begin
          commit = 1'b1;
          phase_next = PH_PREP;
        end
      end
      default: phase_next = PH_PREP;
    endcase
  end

  assign q_pop = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREP;
    end else begin
      phase <= phase_next;
    end
  end

  logic [32:0] raise_sum;
  logic [31:0] raise_sat;
  logic [31:0] fall_val;
  logic [31:0] start_delay;
  logic [31:0] rem;
  logic [31:0] acked_add;

  always_comb begin
    raise_sum = {1'b0, delay_now} + {1'b0, delay_step};
    raise_sat = raise_sum[32] ? 32'hFFFF_FFFF : raise_sum[31:0];
    fall_val = (delay_now > delay_step) ? (delay_now - delay_step) : delay_low;
    start_delay = ((it.dt_max - it.dt_min) >> 2) + it.dt_min;
    rem = file_length - offs_r;
    acked_add = {25'd0, acked_r} * {16'd0, link_mtu};
  end

  result_t res;
  logic [31:0] delay_res;

  always_comb begin
    res = '0;
    delay_res = delay_now;
    res.result_kind = KIND_IGNORED;
    unique case (op_t'(it.operation))
      OP_START: begin
        res.result_kind = KIND_STARTED;
        delay_res = 32'd0;
      end
      OP_ACCEPT: begin
        if (it.seqno == request_seqno && it.well_formed) begin
          res.result_kind = KIND_CONSUMED;
          if (!running) begin
            if (it.peer_status == PST_OK) begin
              delay_res = start_delay;
              res.rearm_timer = 1'b1;
            end else begin
              res.event_res = EV_ABORTED;
            end
          end
        end
      end
      OP_REPORT: begin
        if (it.well_formed && it.session == session_id) begin
          res.result_kind = KIND_STATUS;
          if (!running) begin
            res.reply_status = RSTAT_ABORT;
          end else if (it.peer_status == PST_OK) begin
            res.reply_status = RSTAT_OK;
          end else if (it.peer_status == PST_FINISHED) begin
            res.reply_status = RSTAT_FINISHED;
            res.event_res = EV_FINISHED;
          end else begin
            res.reply_status = RSTAT_ABORT;
            res.event_res = EV_ABORTED;
          end
          if (acked_r <= 7'd8) begin
            delay_res = (raise_sat > delay_high) ? delay_high : raise_sat;
          end else begin
            delay_res = (fall_val < delay_low) ? delay_low : fall_val;
          end
        end
      end
      OP_TICK: begin
        res.result_kind = KIND_IDLE;
        if (running) begin
          if (found_r && offs_r <= file_length) begin
            res.result_kind = KIND_CHUNK;
            res.chunk_index = idx_r;
            res.file_offset = offs_r;
            res.chunk_length = (rem < {16'd0, link_mtu}) ? rem[15:0] : link_mtu;
          end
          res.rearm_timer = acked_total < file_length;
        end
      end
      default: ;
    endcase
    res.delay = delay_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd0;
      delay_step <= 32'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FILE_LENGTH) begin
        file_length <= cfg_data;
      end else if (cfg_index == CFG_DELAY_STEP) begin
        delay_step <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      request_seqno <= 8'hFF;
      link_mtu <= 16'd0;
      session_id <= 16'd0;
      delay_low <= 32'd0;
      delay_high <= 32'd0;
      delay_now <= 32'd0;
      window_base <= 32'd0;
      sent_mask <= 32'd0;
      reported_mask <= 32'd0;
      acked_total <= 32'd0;
    end else if (commit) begin
      delay_now <= delay_res;
      unique case (op_t'(it.operation))
        OP_START: begin
          running <= 1'b0;
          request_seqno <= it.seqno;
          link_mtu <= 16'd0;
          session_id <= 16'd0;
          delay_low <= 32'd0;
          delay_high <= 32'd0;
          window_base <= 32'd0;
          sent_mask <= 32'd0;
          reported_mask <= 32'd0;
          acked_total <= 32'd0;
        end
        OP_ACCEPT: begin
          if (it.seqno == request_seqno && it.well_formed && !running) begin
            request_seqno <= 8'hFF;
            if (it.peer_status == PST_OK) begin
              running <= 1'b1;
              link_mtu <= it.mtu;
              session_id <= it.session;
              delay_low <= it.dt_min;
              delay_high <= it.dt_max;
            end
          end
        end
        OP_REPORT: begin
          if (it.well_formed && it.session == session_id) begin
            if (it.peer_status != PST_OK) begin
              running <= 1'b0;
            end
            acked_total <= acked_total + acked_add;
            window_base <= it.window_offset;
            reported_mask <= it.window_mask;
            sent_mask <= it.window_mask;
          end
        end
        OP_TICK: begin
          if (running && found_r && offs_r <= file_length && it.tx_accepted) begin
            sent_mask[fidx_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_result <= res;
    end
  end

`ifndef SYNTHESIS
  a_pop_in_exec: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (phase == PH_EXEC && q_in.valid))
    else $error("Queue popped outside the execute phase.");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("Committed item produced no result.");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !commit)
    else $error("Result overwritten while stalled.");
  a_start_stops: assert property (@(posedge clk) disable iff (rst)
    (commit && it.operation == OP_START) |=> !running)
    else $error("Start left the transfer running.");
`endif

endmodule
